// ----- rtl/core/kms_pkg.sv -----
// Shared types, command and register codes, and the keypad code table
// for the keypad matrix scanner. No dependencies.
package kms_pkg;

	localparam int ROW_COUNT = 4;
	localparam int COL_COUNT = 3;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	localparam logic [1:0] CFG_SCAN_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_SPECIAL_LEFT  = 2'd1;
	localparam logic [1:0] CFG_SPECIAL_RIGHT = 2'd2;

	localparam logic [7:0] SPECIAL_LEFT_RESET  = 8'd42;
	localparam logic [7:0] SPECIAL_RIGHT_RESET = 8'd35;

	localparam logic [1:0] ROW_SPECIAL = 2'd3;
	localparam logic [1:0] COL_LEFT    = 2'd0;
	localparam logic [1:0] COL_RIGHT   = 2'd2;

	// ASCII digits; the two special keys are replaced by register values.
	localparam logic [7:0] KEY_TABLE [ROW_COUNT][COL_COUNT] = '{
		'{8'h31, 8'h32, 8'h33},
		'{8'h34, 8'h35, 8'h36},
		'{8'h37, 8'h38, 8'h39},
		'{8'h00, 8'h30, 8'h00}
	};

	typedef struct packed {
		logic sample;   // a row sample is in progress with scanning enabled
		logic advance;  // a press other than the last one is taken this cycle
		logic commit;   // the row sample completes this cycle
	} press_ctl_t;

	typedef struct packed {
		logic       any;   // a new press is still waiting
		logic       last;  // at most one new press is waiting
		logic [7:0] code;  // character code of the lowest waiting press
	} press_stat_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       flush;
		logic       load;  // load the read register with this item's popped code, or zero
		logic [7:0] data;
	} queue_ctl_t;

	function automatic logic [7:0] key_char(input logic [1:0] row, input logic [1:0] col,
		input logic [7:0] left_code, input logic [7:0] right_code);
		logic [7:0] c;
		c = KEY_TABLE[row][col];
		if (row == ROW_SPECIAL && col == COL_LEFT) begin
			c = left_code;
		end else if (row == ROW_SPECIAL && col == COL_RIGHT) begin
			c = right_code;
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/kms_press.sv -----
// Press detection for the keypad scanner: per-key previous state, the mask
// of presses already handled for the current row sample, and code lookup.
// Depends on kms_pkg.
module kms_press (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kms_pkg::press_ctl_t  ctl,
	input  logic [1:0]           row,
	input  logic [2:0]           cols,
	input  logic [7:0]           left_code,
	input  logic [7:0]           right_code,
	output kms_pkg::press_stat_t stat
);

	logic [kms_pkg::COL_COUNT-1:0] was_down_q [kms_pkg::ROW_COUNT];
	logic [2:0] done_q;
	logic [2:0] new_mask;
	logic [2:0] rem;
	logic [2:0] pick;
	logic [1:0] col;

	assign new_mask = cols & ~was_down_q[row];
	assign rem      = ctl.sample ? (new_mask & ~done_q) : 3'b000;
	assign pick     = rem & (~rem + 3'd1);

	always_comb begin
		priority if (pick[0]) begin
			col = 2'd0;
		end else if (pick[1]) begin
			col = 2'd1;
		end else begin
			col = 2'd2;
		end
	end

	assign stat.any  = |rem;
	assign stat.last = !((rem[0] & rem[1]) | (rem[0] & rem[2]) | (rem[1] & rem[2]));
	assign stat.code = kms_pkg::key_char(row, col, left_code, right_code);

	// Presses of one sample are handled lowest column first; the previous
	// state of the row is replaced only once the whole sample is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < kms_pkg::ROW_COUNT; r++) begin
				was_down_q[r] <= '0;
			end
			done_q <= 3'b000;
		end else if (ctl.commit) begin
			was_down_q[row] <= cols;
			done_q          <= 3'b000;
		end else if (ctl.advance) begin
			done_q <= done_q | pick;
		end
	end

endmodule

// ----- rtl/core/kms_queue.sv -----
// Key code FIFO: a single-write, single-read memory with head, tail and
// fill count, and a registered read port. Depends on kms_pkg.
module kms_queue #(
	parameter  int QUEUE_DEPTH = 32,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kms_pkg::queue_ctl_t ctl,
	output logic                full,
	output logic                empty,
	output logic [CNT_W-1:0]    fill_next,
	output logic [7:0]          rd_data
);

	logic [7:0]       store_q [QUEUE_DEPTH];
	logic [7:0]       rd_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
		return (slot == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + PTR_W'(1);
	endfunction

	assign full    = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = rd_q;

	always_comb begin
		priority if (ctl.flush) begin
			fill_next = '0;
		end else if (ctl.push) begin
			fill_next = fill_q + CNT_W'(1);
		end else if (ctl.pop) begin
			fill_next = fill_q - CNT_W'(1);
		end else begin
			fill_next = fill_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			store_q[tail_q] <= ctl.data;
		end
		if (ctl.load) begin
			rd_q <= ctl.pop ? store_q[head_q] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (ctl.flush) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= next_slot(tail_q);
			end
			if (ctl.pop) begin
				head_q <= next_slot(head_q);
			end
			fill_q <= fill_next;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count exceeds depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == CNT_W'(QUEUE_DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with an empty or full queue");

	a_push_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (!ctl.pop && !ctl.flush && fill_q != CNT_W'(QUEUE_DEPTH)))
		else $error("push into a full queue or together with pop or flush");

endmodule

// ----- rtl/core/keypad_matrix_scanner_fifo.sv -----
// Keypad matrix scanner (4 rows x 3 columns) with a key code FIFO.
// An accepted item waits in the input stage until its result is registered. A row sample with
// two or three new presses holds the input stage until its last push, as the queue memory
// takes one write per cycle. Throughput: one item per cycle while the result slot is free.
// Reset (arst_n, asynchronous) clears handshake state, previous key state, queue pointers and
// last key, and returns the configuration to scan off, 42 and 35; queue memory is not cleared.
module keypad_matrix_scanner_fifo #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [7:0]                       cfg_data,
	// input items
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       cmd,
	input  logic [1:0]                       row_index,
	input  logic [2:0]                       column_bits,
	// result items
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       key_code,
	output logic                             key_valid,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
	output logic                             overflow,
	output logic [7:0]                       last_key
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration registers.
	logic       scan_enable_q;
	logic [7:0] special_left_q;
	logic [7:0] special_right_q;

	// Input stage: the accepted item waits here until its work is done.
	logic       v_s1;
	logic [1:0] cmd_s1;
	logic [1:0] row_s1;
	logic [2:0] cols_s1;

	// Item-level state.
	logic       ovf_q;
	logic [7:0] recent_key_q;

	// Result register (key_code lives in the queue's read register).
	logic             out_valid_q;
	logic             key_valid_q;
	logic             overflow_q;
	logic [7:0]       last_key_q;
	logic [CNT_W-1:0] queue_count_q;

	kms_pkg::press_ctl_t  pctl;
	kms_pkg::press_stat_t pstat;
	kms_pkg::queue_ctl_t  qctl;
	logic                 q_full;
	logic                 q_empty;
	logic [CNT_W-1:0]     q_fill_next;

	logic out_free;
	logic sample_act;
	logic finish;
	logic push_do;
	logic drop;

	// The result slot is free when empty or being taken this cycle, so a new
	// result can be written while the previous one leaves.
	assign out_free   = !out_valid_q || out_ready;
	assign sample_act = v_s1 && (cmd_s1 == kms_pkg::CMD_SAMPLE) && scan_enable_q;

	// An item finishes when the result slot can take it. A row sample with
	// several new presses first pushes all but the last one, one per cycle,
	// and finishes together with its last push.
	assign finish  = v_s1 && out_free && (!sample_act || pstat.last);
	assign push_do = pstat.any && (finish || !pstat.last);
	assign drop    = push_do && q_full;

	assign in_ready = !v_s1 || finish;

	assign pctl.sample  = sample_act;
	assign pctl.advance = push_do && !finish;
	assign pctl.commit  = finish && sample_act;

	assign qctl.push  = push_do && !q_full;
	assign qctl.pop   = finish && (cmd_s1 == kms_pkg::CMD_POP) && !q_empty;
	assign qctl.flush = finish && (cmd_s1 == kms_pkg::CMD_FLUSH);
	assign qctl.load  = finish;
	assign qctl.data  = pstat.code;

	kms_press u_press (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (pctl),
		.row        (row_s1),
		.cols       (cols_s1),
		.left_code  (special_left_q),
		.right_code (special_right_q),
		.stat       (pstat)
	);

	kms_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (qctl),
		.full      (q_full),
		.empty     (q_empty),
		.fill_next (q_fill_next),
		.rd_data   (key_code)
	);

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q   <= 1'b0;
			special_left_q  <= kms_pkg::SPECIAL_LEFT_RESET;
			special_right_q <= kms_pkg::SPECIAL_RIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kms_pkg::CFG_SCAN_ENABLE:   scan_enable_q   <= cfg_data[0];
				kms_pkg::CFG_SPECIAL_LEFT:  special_left_q  <= cfg_data;
				kms_pkg::CFG_SPECIAL_RIGHT: special_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (finish) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			row_s1  <= row_index;
			cols_s1 <= column_bits;
		end
	end

	// A drop on an early push of a sample is remembered until the sample finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q        <= 1'b0;
			recent_key_q <= 8'h00;
		end else begin
			if (finish) begin
				ovf_q <= 1'b0;
			end else if (drop) begin
				ovf_q <= 1'b1;
			end
			if (push_do) begin
				recent_key_q <= pstat.code;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			key_valid_q   <= qctl.pop;
			overflow_q    <= ovf_q || drop;
			last_key_q    <= push_do ? pstat.code : recent_key_q;
			queue_count_q <= q_fill_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_valid   = key_valid_q;
	assign overflow    = overflow_q;
	assign last_key    = last_key_q;
	assign queue_count = queue_count_q;

	a_pop_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_valid) |-> !overflow)
		else $error("popped result also reports a dropped press");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> queue_count == CNT_W'(QUEUE_DEPTH))
		else $error("dropped press reported while the queue was not full");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !finish) |=> (v_s1 && $stable(cmd_s1) && $stable(row_s1)
			&& $stable(cols_s1)))
		else $error("unfinished item lost from the input stage");

endmodule

// ----- bench/tb_keypad_matrix_scanner_fifo.sv -----
// Self-checking bench for keypad_matrix_scanner_fifo: a directed stimulus table, then random
// phases with several register settings, every result held to a predicted or hand-typed one.
// Depends only on kms_pkg and the keypad_matrix_scanner_fifo RTL.
module tb_keypad_matrix_scanner_fifo;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = 32;
	localparam int QCW = $clog2(QDEPTH + 1);

	// The fourth command code is unused by the block and must act as a no-op.
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_ONE  = 8'h31;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 64;
	localparam int DIRECTED_ROWS = 28;
	localparam int PHASES        = 7;

	// Random phases: item count, share of pops in percent, and whether scanning is on.
	// The first phase pops rarely so the queue fills and drops presses; a later one
	// pops often so the queue runs dry.
	localparam int PHASE_ITEMS [PHASES]   = '{200, 200, 100, 250, 250, 200, 200};
	localparam int PHASE_POP_PCT [PHASES] = '{8, 35, 30, 30, 30, 60, 35};
	localparam bit PHASE_SCAN [PHASES]    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

	typedef struct packed {
		logic [7:0]     key_code;
		logic           key_valid;
		logic [QCW-1:0] queue_count;
		logic           overflow;
		logic [7:0]     last_key;
	} key_result_t;

	// One row of the directed part. Rows with fixed set carry a result typed in by hand;
	// all others take the predictor's answer.
	typedef struct {
		logic [1:0]  op;
		logic [1:0]  row;
		logic [2:0]  cols;
		bit          scan_on_first;
		bit          fixed;
		key_result_t want;
	} stim_row_t;

	localparam key_result_t NO_RESULT = '0;

	logic           clk         = 1'b0;
	logic           arst_n      = 1'b0;
	logic           cfg_we      = 1'b0;
	logic [1:0]     cfg_index   = '0;
	logic [7:0]     cfg_data    = '0;
	logic           in_valid    = 1'b0;
	logic           in_ready;
	logic [1:0]     cmd         = '0;
	logic [1:0]     row_index   = '0;
	logic [2:0]     column_bits = '0;
	logic           out_valid;
	logic           out_ready   = 1'b0;
	logic [7:0]     key_code;
	logic           key_valid;
	logic [QCW-1:0] queue_count;
	logic           overflow;
	logic [7:0]     last_key;

	keypad_matrix_scanner_fifo #(
		.QUEUE_DEPTH(QDEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.row_index  (row_index),
		.column_bits(column_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_code   (key_code),
		.key_valid  (key_valid),
		.queue_count(queue_count),
		.overflow   (overflow),
		.last_key   (last_key)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: a private copy of the registers, the per-key previous-state bits, the
	// queue contents and the last detected key. Values match the block after reset.
	bit          scan_on        = 1'b0;
	logic [7:0]  left_code_cfg  = kms_pkg::SPECIAL_LEFT_RESET;
	logic [7:0]  right_code_cfg = kms_pkg::SPECIAL_RIGHT_RESET;
	bit [11:0]   key_down       = '0;
	logic [7:0]  last_code      = '0;
	logic [7:0]  code_fifo [$];

	// Results still owed by the block, oldest first.
	key_result_t expected_q [$];

	bit         idle_on      = 1'b1;
	bit         hold_req     = 1'b0;
	int         fail_count   = 0;
	int         items_sent   = 0;
	int         results_seen = 0;
	int         pops_seen    = 0;
	int         drops_seen   = 0;
	int         idle_cycles  = 0;
	logic [1:0] sweep_row    = '0;

	// Works out the result of one accepted item and advances the predictor state.
	// Presses are taken lowest column first; a press into a full queue is dropped but
	// still becomes the last key.
	function automatic key_result_t predict_step(input logic [1:0] op, input logic [1:0] row,
		input logic [2:0] cols);
		key_result_t res;
		int          key;
		logic [7:0]  code;
		res = NO_RESULT;
		case (op)
			kms_pkg::CMD_SAMPLE: begin
				if (scan_on) begin
					for (int j = 0; j < kms_pkg::COL_COUNT; j++) begin
						key = row * kms_pkg::COL_COUNT + j;
						if (cols[j] && !key_down[key]) begin
							if (row == kms_pkg::ROW_SPECIAL && j == kms_pkg::COL_LEFT) begin
								code = left_code_cfg;
							end else if (row == kms_pkg::ROW_SPECIAL
								&& j == kms_pkg::COL_RIGHT) begin
								code = right_code_cfg;
							end else if (row == kms_pkg::ROW_SPECIAL) begin
								code = DIGIT_ZERO;
							end else begin
								code = DIGIT_ONE + 8'(key);
							end
							last_code = code;
							if (code_fifo.size() < QDEPTH) begin
								code_fifo.push_back(code);
							end else begin
								res.overflow = 1'b1;
							end
						end
						key_down[key] = cols[j];
					end
				end
			end
			kms_pkg::CMD_POP: begin
				if (code_fifo.size() > 0) begin
					res.key_code  = code_fifo.pop_front();
					res.key_valid = 1'b1;
				end
			end
			kms_pkg::CMD_FLUSH: begin
				code_fifo.delete();
			end
			default: begin
			end
		endcase
		res.queue_count = QCW'(code_fifo.size());
		res.last_key    = last_code;
		return res;
	endfunction

	// Offers one item, possibly after a short idle burst, and waits until the block takes
	// it. The valid line is left high on return so that back-to-back items need no gap.
	task automatic send_item(input logic [1:0] op, input logic [1:0] row, input logic [2:0] cols,
		input bit fixed, input key_result_t want);
		key_result_t predicted;
		int          gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 4)) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		row_index   <= row;
		column_bits <= cols;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_step(op, row, cols);
		expected_q.push_back(fixed ? want : predicted);
		items_sent++;
	endtask

	// Stops offering items and waits until every owed result has come back, then
	// pauses with the block idle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Writes one register while the block is idle and mirrors it in the predictor.
	task automatic write_register(input logic [1:0] index, input logic [7:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			kms_pkg::CFG_SCAN_ENABLE:   scan_on = value[0];
			kms_pkg::CFG_SPECIAL_LEFT:  left_code_cfg = value;
			kms_pkg::CFG_SPECIAL_RIGHT: right_code_cfg = value;
			default: begin
			end
		endcase
	endtask

	// Directed part. It opens with scanning off: every command must leave the status at its
	// reset values. It then enables scanning, presses the special row (left key, zero key,
	// right key), pops one code, holds and releases the row, and fills the queue by sweeping
	// the rows with every column down until the last sweep overflows. A pop at full and a
	// flush close it; the flush keeps the last key.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{kms_pkg::CMD_POP,    2'd0, 3'd0, 1'b0, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 8'h00}},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd7, 1'b0, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 8'h00}},
		'{CMD_NONE,            2'd2, 3'd5, 1'b0, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 8'h00}},
		'{kms_pkg::CMD_FLUSH,  2'd1, 3'd2, 1'b0, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 8'h00}},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd7, 1'b1, 1'b1,
			'{8'h00, 1'b0, 6'd3, 1'b0, kms_pkg::SPECIAL_RIGHT_RESET}},
		'{kms_pkg::CMD_POP,    2'd0, 3'd0, 1'b0, 1'b1,
			'{kms_pkg::SPECIAL_LEFT_RESET, 1'b1, 6'd2, 1'b0,
				kms_pkg::SPECIAL_RIGHT_RESET}},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd7, 1'b0, 1'b1,
			'{8'h00, 1'b0, 6'd2, 1'b0, kms_pkg::SPECIAL_RIGHT_RESET}},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd0, 1'b0, 1'b1,
			'{8'h00, 1'b0, 6'd2, 1'b0, kms_pkg::SPECIAL_RIGHT_RESET}},
		'{kms_pkg::CMD_SAMPLE, 2'd0, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd1, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd2, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd0, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd1, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd2, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd0, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd1, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd2, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd3, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd0, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd1, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd2, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd0, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd1, 3'd7, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_SAMPLE, 2'd2, 3'd7, 1'b0, 1'b1,
			'{8'h00, 1'b0, 6'd32, 1'b1, 8'h39}},
		'{kms_pkg::CMD_POP,    2'd0, 3'd0, 1'b0, 1'b0, NO_RESULT},
		'{kms_pkg::CMD_FLUSH,  2'd0, 3'd0, 1'b0, 1'b1, '{8'h00, 1'b0, 6'd0, 1'b0, 8'h39}}
	};

	// Result side: the ready line is driven at falling edges. It stalls in short random
	// bursts while idling is on, and once holds off for a long stretch on request so the
	// output register fills and the block has to stall its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Every accepted result is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result with no item waiting: key_code %0d, queue_count %0d",
					key_code, queue_count);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (key_code !== want.key_code) begin
					$error("key_code: expected %0d, got %0d", want.key_code, key_code);
					fail_count++;
				end
				if (key_valid !== want.key_valid) begin
					$error("key_valid: expected %0d, got %0d", want.key_valid, key_valid);
					fail_count++;
				end
				if (queue_count !== want.queue_count) begin
					$error("queue_count: expected %0d, got %0d", want.queue_count, queue_count);
					fail_count++;
				end
				if (overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, overflow);
					fail_count++;
				end
				if (last_key !== want.last_key) begin
					$error("last_key: expected %0d, got %0d", want.last_key, last_key);
					fail_count++;
				end
				pops_seen += want.key_valid;
				drops_seen += want.overflow;
			end
		end
	end

	// Watchdog: the run is stuck if no item moves on either side for too long. The long
	// receiver hold-off stays far below the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int         pick;
		int         pop_pct;
		int         shape;
		logic [1:0] op;
		logic [1:0] row;
		logic [2:0] cols;
		logic [7:0] left_value;
		logic [7:0] right_value;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			if (directed_rows[n].scan_on_first) begin
				drain_results();
				write_register(kms_pkg::CFG_SCAN_ENABLE, 8'd1);
			end
			send_item(directed_rows[n].op, directed_rows[n].row, directed_rows[n].cols,
				directed_rows[n].fixed, directed_rows[n].want);
		end

		// Random phases. Most samples follow a regular row sweep with sparse column
		// patterns, the way a real scanner reports a keypad; the rest are pops, flushes,
		// unused commands and samples of random rows with random columns.
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			idle_on = (p != PHASES - 1);
			case (p)
				0: begin
					left_value  = 8'h00;
					right_value = 8'hFF;
				end
				1: begin
					left_value  = 8'hFF;
					right_value = 8'h00;
				end
				4: begin
					left_value  = kms_pkg::SPECIAL_LEFT_RESET;
					right_value = kms_pkg::SPECIAL_RIGHT_RESET;
				end
				default: begin
					left_value  = 8'($urandom_range(0, 255));
					right_value = 8'($urandom_range(0, 255));
				end
			endcase
			write_register(kms_pkg::CFG_SCAN_ENABLE, {7'd0, PHASE_SCAN[p]});
			write_register(kms_pkg::CFG_SPECIAL_LEFT, left_value);
			write_register(kms_pkg::CFG_SPECIAL_RIGHT, right_value);
			pop_pct = PHASE_POP_PCT[p];

			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				// One long receiver hold-off while items keep coming, and one pause of
				// the sender until every owed result is back.
				if (p == 1 && i == 40) begin
					hold_req = 1'b1;
				end
				if (p == 3 && i == 120) begin
					drain_results();
				end
				pick = $urandom_range(0, 99);
				row  = 2'($urandom_range(0, 3));
				cols = 3'($urandom_range(0, 7));
				if (pick < pop_pct) begin
					op = kms_pkg::CMD_POP;
				end else if (pick < pop_pct + 2) begin
					op = kms_pkg::CMD_FLUSH;
				end else if (pick < pop_pct + 3) begin
					op = CMD_NONE;
				end else begin
					op = kms_pkg::CMD_SAMPLE;
					if (pick >= pop_pct + 6) begin
						row = sweep_row;
						sweep_row = sweep_row + 2'd1;
						shape = $urandom_range(0, 19);
						if (shape < 13) begin
							cols = 3'd0;
						end else if (shape < 18) begin
							cols = 3'b001 << $urandom_range(0, 2);
						end
					end
				end
				send_item(op, row, cols, 1'b0, NO_RESULT);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);

		$display("Run covered %0d items under %0d register settings: %0d results checked,",
			items_sent, PHASES + 2, results_seen);
		$display("%0d codes popped and %0d steps with dropped presses.", pops_seen, drops_seen);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- keypad_matrix_scanner_fifo.f -----
rtl/core/kms_pkg.sv
rtl/core/kms_press.sv
rtl/core/kms_queue.sv
rtl/core/keypad_matrix_scanner_fifo.sv
bench/tb_keypad_matrix_scanner_fifo.sv
